/* sv/bqc_pkg.sv */
// Shared types and constants of the biquad coefficient calculator.
package bqc_pkg;

  localparam int COEF_WIDTH  = 32;
  localparam int COEF_FRAC   = COEF_WIDTH - 8;
  localparam int NUM_COEF    = 5;
  localparam int FRONT_STEPS = 64;
  localparam int ROOT_STEPS  = 32;

  localparam logic [63:0] ONE_Q24   = 64'd16777216;
  // floor(sqrt(2) * 2^24)
  localparam logic [24:0] SQRT2_Q24 = 25'd23726566;

  localparam logic [COEF_WIDTH-1:0] SAT_POS = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] SAT_NEG = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  localparam logic [3:0] FN_LOWPASS   = 4'd0;
  localparam logic [3:0] FN_HIGHPASS  = 4'd1;
  localparam logic [3:0] FN_BANDPASS  = 4'd2;
  localparam logic [3:0] FN_NOTCH     = 4'd3;
  localparam logic [3:0] FN_PEAK      = 4'd4;
  localparam logic [3:0] FN_LOWSHELF  = 4'd5;
  localparam logic [3:0] FN_HIGHSHELF = 4'd6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNSUP = 2'd1,
    ST_DIV0  = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  // data passed along the divide / square root chain
  typedef struct packed {
    logic [31:0] q;
    logic [63:0] kq_nq;
    logic [31:0] kq_rem;
    logic [63:0] vkq_nq;
    logic [31:0] vkq_rem;
    logic [63:0] sq_rad;
    logic [33:0] sq_rem;
    logic [31:0] sq_root;
    logic [3:0]  func;
    logic        cut;
    logic [31:0] k;
    logic [31:0] v;
    logic [31:0] k2;
    logic [38:0] vk2;
    logic [28:0] s2k;
  } front_t;

  typedef struct packed {
    logic [63:0]           rem;
    logic [COEF_WIDTH-1:0] nq;
    logic                  neg;
    logic                  ovf;
  } lane_t;

  // data passed along the coefficient divider chain
  typedef struct packed {
    lane_t [NUM_COEF-1:0] lane;
    logic [63:0]          den;
    status_t              err;
  } coef_t;

endpackage

/* sv/bqc_front_cell.sv */
// One step of the K/Q and VK/Q dividers and, when root_step is high, of the square root of 2V.
module bqc_front_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            root_step,
  input  logic            vld_i,
  input  bqc_pkg::front_t d_i,
  output logic            vld_o,
  output bqc_pkg::front_t d_o
);
  import bqc_pkg::*;

  logic        vld_r;
  front_t      d_r, d_nxt;
  logic [32:0] kt, vt;
  logic [33:0] st, trial;

  always_comb begin
    d_nxt = d_i;
    kt    = {d_i.kq_rem, d_i.kq_nq[63]};
    vt    = {d_i.vkq_rem, d_i.vkq_nq[63]};
    st    = {d_i.sq_rem[31:0], d_i.sq_rad[63:62]};
    trial = {d_i.sq_root, 2'b01};

    if (kt >= {1'b0, d_i.q}) begin
      d_nxt.kq_rem = 32'(kt - {1'b0, d_i.q});
      d_nxt.kq_nq  = {d_i.kq_nq[62:0], 1'b1};
    end else begin
      d_nxt.kq_rem = kt[31:0];
      d_nxt.kq_nq  = {d_i.kq_nq[62:0], 1'b0};
    end

    if (vt >= {1'b0, d_i.q}) begin
      d_nxt.vkq_rem = 32'(vt - {1'b0, d_i.q});
      d_nxt.vkq_nq  = {d_i.vkq_nq[62:0], 1'b1};
    end else begin
      d_nxt.vkq_rem = vt[31:0];
      d_nxt.vkq_nq  = {d_i.vkq_nq[62:0], 1'b0};
    end

    // restoring square root, two radicand bits per step
    if (root_step) begin
      d_nxt.sq_rad = {d_i.sq_rad[61:0], 2'b00};
      if (st >= trial) begin
        d_nxt.sq_rem  = st - trial;
        d_nxt.sq_root = {d_i.sq_root[30:0], 1'b1};
      end else begin
        d_nxt.sq_rem  = st;
        d_nxt.sq_root = {d_i.sq_root[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

/* sv/bqc_terms.sv */
// Product, sum and sign stages that turn the chain results into divider lanes.
module bqc_terms (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  bqc_pkg::front_t f_i,
  output logic            vld_o,
  output bqc_pkg::coef_t  c_o
);
  import bqc_pkg::*;

  // stage S: sqrt(2V) * K
  logic        vld_s_r;
  front_t      f_s_r;
  logic [32:0] svk_s_r;
  logic [63:0] svk_prod;

  // stage T: numerator terms and denominator
  logic        vld_t_r;
  logic [63:0] p_t_r [NUM_COEF];
  logic [63:0] n_t_r [NUM_COEF];
  logic [63:0] den_t_r;
  status_t     err_t_r;
  logic [63:0] p_nxt [NUM_COEF];
  logic [63:0] n_nxt [NUM_COEF];
  logic [63:0] den_nxt;
  status_t     err_nxt;
  logic [63:0] kq, vkq, k2w, vk2w, svkw, s2kw, vw;

  // stage U: magnitude and sign
  logic        vld_u_r;
  logic [63:0] m_u_r [NUM_COEF];
  logic        neg_u_r [NUM_COEF];
  logic [63:0] den_u_r;
  status_t     err_u_r;

  // stage V: first divider step (overflow test)
  logic          vld_v_r;
  coef_t         c_r, c_nxt;
  logic [127:0]  num [NUM_COEF];

  assign svk_prod = f_i.sq_root * f_i.k;

  always_ff @(posedge clk) begin
    if (en) begin
      f_s_r   <= f_i;
      svk_s_r <= svk_prod[60:28];
    end
  end

  assign kq   = f_s_r.kq_nq;
  assign vkq  = f_s_r.vkq_nq;
  assign k2w  = {32'b0, f_s_r.k2};
  assign vk2w = {25'b0, f_s_r.vk2};
  assign svkw = {31'b0, svk_s_r};
  assign s2kw = {35'b0, f_s_r.s2k};
  assign vw   = {32'b0, f_s_r.v};

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      p_nxt[i] = '0;
      n_nxt[i] = '0;
    end
    den_nxt  = ONE_Q24 + kq + k2w;
    p_nxt[3] = k2w;
    n_nxt[3] = ONE_Q24;
    p_nxt[4] = ONE_Q24 + k2w;
    n_nxt[4] = kq;

    case (f_s_r.func)
      FN_LOWPASS: begin
        p_nxt[0] = k2w;
        p_nxt[1] = k2w;
        p_nxt[2] = k2w;
      end
      FN_HIGHPASS: begin
        p_nxt[0] = ONE_Q24;
        n_nxt[1] = ONE_Q24;
        p_nxt[2] = ONE_Q24;
      end
      FN_BANDPASS: begin
        p_nxt[0] = kq;
        n_nxt[2] = kq;
      end
      FN_NOTCH: begin
        p_nxt[0] = ONE_Q24 + k2w;
        p_nxt[1] = k2w;
        n_nxt[1] = ONE_Q24;
        p_nxt[2] = ONE_Q24 + k2w;
      end
      FN_PEAK: begin
        p_nxt[1] = k2w;
        n_nxt[1] = ONE_Q24;
        if (!f_s_r.cut) begin
          p_nxt[0] = ONE_Q24 + vkq + k2w;
          p_nxt[2] = ONE_Q24 + k2w;
          n_nxt[2] = vkq;
        end else begin
          den_nxt  = ONE_Q24 + vkq + k2w;
          p_nxt[0] = ONE_Q24 + kq + k2w;
          p_nxt[2] = ONE_Q24 + k2w;
          n_nxt[2] = kq;
          p_nxt[4] = ONE_Q24 + k2w;
          n_nxt[4] = vkq;
        end
      end
      FN_LOWSHELF: begin
        if (!f_s_r.cut) begin
          den_nxt  = ONE_Q24 + s2kw + k2w;
          p_nxt[0] = ONE_Q24 + svkw + vk2w;
          p_nxt[1] = vk2w;
          n_nxt[1] = ONE_Q24;
          p_nxt[2] = ONE_Q24 + vk2w;
          n_nxt[2] = svkw;
          p_nxt[4] = ONE_Q24 + k2w;
          n_nxt[4] = s2kw;
        end else begin
          den_nxt  = ONE_Q24 + svkw + vk2w;
          p_nxt[0] = ONE_Q24 + s2kw + k2w;
          p_nxt[1] = k2w;
          n_nxt[1] = ONE_Q24;
          p_nxt[2] = ONE_Q24 + k2w;
          n_nxt[2] = s2kw;
          p_nxt[3] = vk2w;
          n_nxt[3] = ONE_Q24;
          p_nxt[4] = ONE_Q24 + vk2w;
          n_nxt[4] = svkw;
        end
      end
      FN_HIGHSHELF: begin
        if (!f_s_r.cut) begin
          den_nxt  = ONE_Q24 + s2kw + k2w;
          p_nxt[0] = vw + svkw + k2w;
          p_nxt[1] = k2w;
          n_nxt[1] = vw;
          p_nxt[2] = vw + k2w;
          n_nxt[2] = svkw;
          p_nxt[4] = ONE_Q24 + k2w;
          n_nxt[4] = s2kw;
        end else begin
          den_nxt  = vw + svkw + k2w;
          p_nxt[0] = ONE_Q24 + s2kw + k2w;
          p_nxt[1] = k2w;
          n_nxt[1] = ONE_Q24;
          p_nxt[2] = ONE_Q24 + k2w;
          n_nxt[2] = s2kw;
          p_nxt[3] = k2w;
          n_nxt[3] = vw;
          p_nxt[4] = vw + k2w;
          n_nxt[4] = svkw;
        end
      end
      default: begin
      end
    endcase

    if (f_s_r.func > FN_HIGHSHELF) begin
      err_nxt = ST_UNSUP;
    end else if (f_s_r.q == 32'd0) begin
      err_nxt = ST_DIV0;
    end else begin
      err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        p_t_r[i] <= p_nxt[i];
        n_t_r[i] <= n_nxt[i];
      end
      den_t_r <= den_nxt;
      err_t_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        neg_u_r[i] <= n_t_r[i] > p_t_r[i];
        m_u_r[i]   <= (n_t_r[i] > p_t_r[i]) ? n_t_r[i] - p_t_r[i] : p_t_r[i] - n_t_r[i];
      end
      den_u_r <= den_t_r;
      if (err_t_r == ST_OK && den_t_r == 64'd0) begin
        err_u_r <= ST_DIV0;
      end else begin
        err_u_r <= err_t_r;
      end
    end
  end

  // b1 and a1 carry the factor two
  always_comb begin
    c_nxt     = '0;
    c_nxt.den = den_u_r;
    c_nxt.err = err_u_r;
    for (int i = 0; i < NUM_COEF; i++) begin
      num[i] = {64'b0, m_u_r[i]} << (COEF_FRAC + ((i == 1 || i == 3) ? 1 : 0));
      c_nxt.lane[i].rem = num[i][COEF_WIDTH+63:COEF_WIDTH];
      c_nxt.lane[i].nq  = num[i][COEF_WIDTH-1:0];
      c_nxt.lane[i].neg = neg_u_r[i];
      c_nxt.lane[i].ovf = num[i][COEF_WIDTH+63:COEF_WIDTH] >= den_u_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s_r <= 1'b0;
      vld_t_r <= 1'b0;
      vld_u_r <= 1'b0;
      vld_v_r <= 1'b0;
    end else if (en) begin
      vld_s_r <= vld_i;
      vld_t_r <= vld_s_r;
      vld_u_r <= vld_t_r;
      vld_v_r <= vld_u_r;
    end
  end

  assign vld_o = vld_v_r;
  assign c_o   = c_r;

endmodule

/* sv/bqc_coef_cell.sv */
// One quotient bit for all five coefficient dividers.
module bqc_coef_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  bqc_pkg::coef_t c_i,
  output logic           vld_o,
  output bqc_pkg::coef_t c_o
);
  import bqc_pkg::*;

  logic        vld_r;
  coef_t       c_r, c_nxt;
  logic [64:0] t [NUM_COEF];

  always_comb begin
    c_nxt = c_i;
    for (int i = 0; i < NUM_COEF; i++) begin
      t[i] = {c_i.lane[i].rem, c_i.lane[i].nq[COEF_WIDTH-1]};
      if (t[i] >= {1'b0, c_i.den}) begin
        c_nxt.lane[i].rem = 64'(t[i] - {1'b0, c_i.den});
        c_nxt.lane[i].nq  = {c_i.lane[i].nq[COEF_WIDTH-2:0], 1'b1};
      end else begin
        c_nxt.lane[i].rem = t[i][63:0];
        c_nxt.lane[i].nq  = {c_i.lane[i].nq[COEF_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign vld_o = vld_r;
  assign c_o   = c_r;

endmodule

/* sv/biquad_coefficient_calculator.sv */
// Top level of the biquad coefficient calculator: input stages, cell chains, term stages, output register.
//
// Usage: one request on the in_ channel (in_valid, in_stall; func, K, Q, gain) gives
// one result on the out_ channel (out_valid, out_stall; five coefficients, status).
// A request is taken at an edge where in_valid is high and in_stall is low; a result
// is taken where out_valid is high and out_stall is low.
// Throughput: one request per cycle while nothing stalls. The block is a fixed pipeline:
// three input stages, 64 cells that each retire one bit of K/Q and VK/Q (the first 32
// also one bit of sqrt(2V)), four term/sign stages, one cell per coefficient bit (32 at
// the default width) and the output register.
// While out_stall holds a waiting result, the whole pipeline freezes and in_stall is
// high; the output register lets a new request in whenever the result is taken.
// Reset (rst_n low, synchronous) empties the pipeline; no result is pending after it.
// Status: 0 ok, 1 unsupported type (zeros), 2 zero Q or denominator (zeros),
// 3 at least one coefficient saturated.
module biquad_coefficient_calculator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [3:0]                           in_func,
  input  logic [31:0]                          in_k_factor,
  input  logic [31:0]                          in_quality,
  input  logic signed [31:0]                   in_gain_linear,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bqc_pkg::COEF_WIDTH-1:0] out_coef_a0,
  output logic signed [bqc_pkg::COEF_WIDTH-1:0] out_coef_a1,
  output logic signed [bqc_pkg::COEF_WIDTH-1:0] out_coef_a2,
  output logic signed [bqc_pkg::COEF_WIDTH-1:0] out_coef_b1,
  output logic signed [bqc_pkg::COEF_WIDTH-1:0] out_coef_b2,
  output logic [1:0]                           out_status
);
  import bqc_pkg::*;

  logic en;

  // stage 1: magnitude and branch
  logic        vld1_r, cut1_r;
  logic [3:0]  func1_r;
  logic [31:0] k1_r, q1_r, v1_r;

  // stage 2: products of the inputs
  logic        vld2_r, cut2_r;
  logic [3:0]  func2_r;
  logic [31:0] k2in_r, q2_r, v2_r, ksq_r;
  logic [63:0] vk_r;
  logic [28:0] s2k_r;
  logic [63:0] kk_prod;
  logic [63:0] vk_prod;
  logic [56:0] s2k_prod;

  // stage 3: V*K2 and chain entry
  logic        vld3_r;
  front_t      f3_r, f3_nxt;
  logic [63:0] vk2_prod;

  logic        fvld [FRONT_STEPS+1];
  front_t      fd   [FRONT_STEPS+1];
  logic        tvld;
  coef_t       tc;
  logic        cvld [COEF_WIDTH+1];
  coef_t       cd   [COEF_WIDTH+1];

  logic                  out_valid_r;
  logic [COEF_WIDTH-1:0] coef_r [NUM_COEF];
  status_t               status_r;
  logic [COEF_WIDTH-1:0] val_nxt [NUM_COEF];
  logic                  sat_nxt [NUM_COEF];
  status_t               status_nxt;
  coef_t                 cl;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (en) begin
      func1_r <= in_func;
      k1_r    <= in_k_factor;
      q1_r    <= in_quality;
      cut1_r  <= in_gain_linear[31];
      v1_r    <= in_gain_linear[31] ? 32'(~$unsigned(in_gain_linear) + 32'd1)
                                    : $unsigned(in_gain_linear);
    end
  end

  assign kk_prod  = k1_r * k1_r;
  assign vk_prod  = v1_r * k1_r;
  assign s2k_prod = SQRT2_Q24 * k1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      func2_r <= func1_r;
      cut2_r  <= cut1_r;
      k2in_r  <= k1_r;
      q2_r    <= q1_r;
      v2_r    <= v1_r;
      ksq_r   <= kk_prod[63:32];
      vk_r    <= vk_prod;
      s2k_r   <= s2k_prod[56:28];
    end
  end

  assign vk2_prod = v2_r * ksq_r;

  always_comb begin
    f3_nxt         = '0;
    f3_nxt.q       = q2_r;
    f3_nxt.kq_nq   = {8'b0, k2in_r, 24'b0};
    f3_nxt.vkq_nq  = vk_r;
    f3_nxt.sq_rad  = {7'b0, v2_r, 25'b0};
    f3_nxt.func    = func2_r;
    f3_nxt.cut     = cut2_r;
    f3_nxt.k       = k2in_r;
    f3_nxt.v       = v2_r;
    f3_nxt.k2      = ksq_r;
    f3_nxt.vk2     = vk2_prod[62:24];
    f3_nxt.s2k     = s2k_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r <= f3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  assign fvld[0] = vld3_r;
  assign fd[0]   = f3_r;

  for (genvar i = 0; i < FRONT_STEPS; i++) begin : g_front
    bqc_front_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .root_step (i < ROOT_STEPS),
      .vld_i     (fvld[i]),
      .d_i       (fd[i]),
      .vld_o     (fvld[i+1]),
      .d_o       (fd[i+1])
    );
  end

  bqc_terms u_terms (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (fvld[FRONT_STEPS]),
    .f_i   (fd[FRONT_STEPS]),
    .vld_o (tvld),
    .c_o   (tc)
  );

  assign cvld[0] = tvld;
  assign cd[0]   = tc;

  for (genvar j = 0; j < COEF_WIDTH; j++) begin : g_coef
    bqc_coef_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cvld[j]),
      .c_i   (cd[j]),
      .vld_o (cvld[j+1]),
      .c_o   (cd[j+1])
    );
  end

  assign cl = cd[COEF_WIDTH];

  always_comb begin
    for (int i = 0; i < NUM_COEF; i++) begin
      if (cl.lane[i].neg) begin
        sat_nxt[i] = cl.lane[i].ovf || (cl.lane[i].nq > SAT_NEG);
        val_nxt[i] = sat_nxt[i] ? SAT_NEG : COEF_WIDTH'(~cl.lane[i].nq + 1'b1);
      end else begin
        sat_nxt[i] = cl.lane[i].ovf || (cl.lane[i].nq > SAT_POS);
        val_nxt[i] = sat_nxt[i] ? SAT_POS : cl.lane[i].nq;
      end
    end
    if (cl.err != ST_OK) begin
      status_nxt = cl.err;
      for (int i = 0; i < NUM_COEF; i++) begin
        val_nxt[i] = '0;
      end
    end else if (sat_nxt[0] || sat_nxt[1] || sat_nxt[2] || sat_nxt[3] || sat_nxt[4]) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cvld[COEF_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= val_nxt[i];
      end
      status_r <= status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_coef_a0 = coef_r[0];
  assign out_coef_a1 = coef_r[1];
  assign out_coef_a2 = coef_r[2];
  assign out_coef_b1 = coef_r[3];
  assign out_coef_b2 = coef_r[4];
  assign out_status  = status_r;

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNSUP |->
      out_coef_a0 == 0 && out_coef_a1 == 0 && out_coef_a2 == 0 &&
      out_coef_b1 == 0 && out_coef_b2 == 0)
    else $error("unsupported type with nonzero coefficients");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |->
      out_coef_a0 == 0 && out_coef_a1 == 0 && out_coef_a2 == 0 &&
      out_coef_b1 == 0 && out_coef_b2 == 0)
    else $error("zero divisor with nonzero coefficients");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |->
      coef_r[0] == SAT_POS || coef_r[0] == SAT_NEG ||
      coef_r[1] == SAT_POS || coef_r[1] == SAT_NEG ||
      coef_r[2] == SAT_POS || coef_r[2] == SAT_NEG ||
      coef_r[3] == SAT_POS || coef_r[3] == SAT_NEG ||
      coef_r[4] == SAT_POS || coef_r[4] == SAT_NEG)
    else $error("saturation status without a limit value");

endmodule
